FILE: hw/rtl/aen_pkg.sv
// package for the averaged edge normal pipeline: widths, depths and carried types
package aen_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned SH_W     = 24;
  localparam int unsigned K_W      = 4;
  localparam int unsigned K_MAX    = SUM_W - SH_W;
  localparam int unsigned SQR_W    = 2 * SH_W;
  localparam int unsigned L2_W     = SQR_W + 2;
  localparam int unsigned FRAC_SH  = 12;
  localparam int unsigned RAD_W    = L2_W + FRAC_SH;
  localparam int unsigned ROOT_W   = (RAD_W + 1) / 2;
  localparam int unsigned NUM_SH   = 20;
  localparam int unsigned NUM_W    = SH_W + NUM_SH + 1;
  localparam int unsigned Q_W      = 16;
  localparam int unsigned DREM_W   = NUM_W + 2;
  localparam int unsigned OUT_W    = 16;
  localparam logic [Q_W-1:0] UNIT_ONE = Q_W'(16384);

  // item data carried alongside the root and divide stages
  typedef struct packed {
    logic [2:0][SH_W-1:0] sh;
    logic [2:0]           neg;
    logic                 dg;
  } carry_t;

endpackage

FILE: hw/rtl/averaged_edge_normal.sv
// averaged two-face vertex normal, fully pipelined, unit length in Q1.14
//
// Takes a center, a shared edge vertex and two side vertices (Q7.8) and returns
// the normalized sum of the two face normals (S-C)x(S-A) and (S-C)x(S-B) in Q1.14,
// with degenerate set and a zero vector when the sum is zero. One item enters per
// cycle while not stalled. The 31 one-bit square root stages and the
// 16 one-bit divide stages follow the cross products. When out_stall holds a
// waiting result the whole pipeline freezes and in_stall rises in the same cycle.
module averaged_edge_normal
  import aen_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic signed [COORD_W-1:0] center_z,
  input  logic signed [COORD_W-1:0] shared_x,
  input  logic signed [COORD_W-1:0] shared_y,
  input  logic signed [COORD_W-1:0] shared_z,
  input  logic signed [COORD_W-1:0] side_a_x,
  input  logic signed [COORD_W-1:0] side_a_y,
  input  logic signed [COORD_W-1:0] side_a_z,
  input  logic signed [COORD_W-1:0] side_b_x,
  input  logic signed [COORD_W-1:0] side_b_y,
  input  logic signed [COORD_W-1:0] side_b_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   normal_x,
  output logic signed [OUT_W-1:0]   normal_y,
  output logic signed [OUT_W-1:0]   normal_z,
  output logic                      degenerate
);

  localparam int unsigned FRONT = 8;
  localparam int unsigned NSTG  = FRONT + ROOT_W + 1 + Q_W + 1;

  logic            en;
  logic [NSTG:1]   vld;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[NSTG];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-1:1], in_valid};
    end
  end

  // stage 1: edge differences
  logic signed [DIFF_W-1:0] d [3];
  logic signed [DIFF_W-1:0] ea [3];
  logic signed [DIFF_W-1:0] eb [3];

  always_ff @(posedge clk) begin
    if (en) begin
      d[0]  <= DIFF_W'(shared_x) - DIFF_W'(center_x);
      d[1]  <= DIFF_W'(shared_y) - DIFF_W'(center_y);
      d[2]  <= DIFF_W'(shared_z) - DIFF_W'(center_z);
      ea[0] <= DIFF_W'(shared_x) - DIFF_W'(side_a_x);
      ea[1] <= DIFF_W'(shared_y) - DIFF_W'(side_a_y);
      ea[2] <= DIFF_W'(shared_z) - DIFF_W'(side_a_z);
      eb[0] <= DIFF_W'(shared_x) - DIFF_W'(side_b_x);
      eb[1] <= DIFF_W'(shared_y) - DIFF_W'(side_b_y);
      eb[2] <= DIFF_W'(shared_z) - DIFF_W'(side_b_z);
    end
  end

  // stage 2: cross product terms, plus and minus part per component per face
  logic signed [PROD_W-1:0] pa_p [3];
  logic signed [PROD_W-1:0] pa_m [3];
  logic signed [PROD_W-1:0] pb_p [3];
  logic signed [PROD_W-1:0] pb_m [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_p[i] <= PROD_W'(d[(i+1)%3]) * PROD_W'(ea[(i+2)%3]);
        pa_m[i] <= PROD_W'(d[(i+2)%3]) * PROD_W'(ea[(i+1)%3]);
        pb_p[i] <= PROD_W'(d[(i+1)%3]) * PROD_W'(eb[(i+2)%3]);
        pb_m[i] <= PROD_W'(d[(i+2)%3]) * PROD_W'(eb[(i+1)%3]);
      end
    end
  end

  // stage 3: sum of the two face normals
  logic signed [SUM_W-1:0] sum [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sum[i] <= (SUM_W'(pa_p[i]) - SUM_W'(pa_m[i])) + (SUM_W'(pb_p[i]) - SUM_W'(pb_m[i]));
      end
    end
  end

  // stage 4: magnitudes and signs
  logic [SUM_W-1:0] mag [3];
  logic [2:0]       neg4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag[i]  <= sum[i][SUM_W-1] ? SUM_W'(-sum[i]) : SUM_W'(sum[i]);
        neg4[i] <= sum[i][SUM_W-1];
      end
    end
  end

  // stage 5: largest magnitude picks the shift into 24 bits
  logic [SUM_W-1:0] mx;
  logic [K_W-1:0]   k_next;
  logic [K_W-1:0]   k5;
  logic [SUM_W-1:0] mag5 [3];
  logic [2:0]       neg5;
  logic             dg5;

  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    k_next = '0;
    for (int j = 0; j <= int'(K_MAX); j++) begin
      if ((mx >> j) >= (SUM_W'(1) << SH_W)) k_next = K_W'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k5   <= k_next;
      mag5 <= mag;
      neg5 <= neg4;
      dg5  <= (mx == '0);
    end
  end

  // stage 6: scaled magnitudes
  carry_t c6;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c6.sh[i] <= SH_W'(mag5[i] >> k5);
      end
      c6.neg <= neg5;
      c6.dg  <= dg5;
    end
  end

  // stage 7: squares
  logic [SQR_W-1:0] sq [3];
  carry_t           c7;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SQR_W'(c6.sh[i]) * SQR_W'(c6.sh[i]);
      end
      c7 <= c6;
    end
  end

  // stage 8: squared length with fraction bits for the root
  logic [RAD_W-1:0] rt_rem [ROOT_W+1];
  logic [ROOT_W-1:0] rt_res [ROOT_W+1];
  carry_t           rt_c   [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rt_rem[0] <= {(L2_W'(sq[0]) + L2_W'(sq[1]) + L2_W'(sq[2])), {FRAC_SH{1'b0}}};
      rt_res[0] <= '0;
      rt_c[0]   <= c7;
    end
  end

  // square root, one result bit per stage
  for (genvar t = 0; t < ROOT_W; t++) begin : g_root
    localparam int unsigned B = ROOT_W - 1 - t;
    logic [RAD_W+1:0] trial;
    assign trial = ((RAD_W+2)'(rt_res[t]) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if ((RAD_W+2)'(rt_rem[t]) >= trial) begin
          rt_rem[t+1] <= RAD_W'((RAD_W+2)'(rt_rem[t]) - trial);
          rt_res[t+1] <= rt_res[t] | (ROOT_W'(1) << B);
        end else begin
          rt_rem[t+1] <= rt_rem[t];
          rt_res[t+1] <= rt_res[t];
        end
        rt_c[t+1] <= rt_c[t];
      end
    end
  end

  // numerators with half-divisor rounding
  logic [NUM_W-1:0]  dv_rem [Q_W+1][3];
  logic [Q_W-1:0]    dv_q   [Q_W+1][3];
  logic [ROOT_W-1:0] dv_r   [Q_W+1];
  carry_t            dv_c   [Q_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= {1'b0, rt_c[ROOT_W].sh[i], {NUM_SH{1'b0}}}
                      + NUM_W'(rt_res[ROOT_W] >> 1);
        dv_q[0][i]   <= '0;
      end
      dv_r[0] <= rt_res[ROOT_W];
      dv_c[0] <= rt_c[ROOT_W];
    end
  end

  // restoring divide, one quotient bit per stage, three lanes
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int unsigned B = Q_W - 1 - j;
    logic [DREM_W-1:0] dsh;
    assign dsh = DREM_W'(dv_r[j]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (DREM_W'(dv_rem[j][i]) >= dsh) begin
            dv_rem[j+1][i] <= NUM_W'(DREM_W'(dv_rem[j][i]) - dsh);
            dv_q[j+1][i]   <= dv_q[j][i] | (Q_W'(1) << B);
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
            dv_q[j+1][i]   <= dv_q[j][i];
          end
        end
        dv_r[j+1] <= dv_r[j];
        dv_c[j+1] <= dv_c[j];
      end
    end
  end

  // output register: clamp, sign, degenerate override
  logic [Q_W-1:0]          qc  [3];
  logic signed [OUT_W-1:0] nv  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q[Q_W][i] > UNIT_ONE) ? UNIT_ONE : dv_q[Q_W][i];
      if (dv_c[Q_W].dg) begin
        nv[i] = '0;
      end else if (dv_c[Q_W].neg[i]) begin
        nv[i] = OUT_W'(-qc[i]);
      end else begin
        nv[i] = OUT_W'(qc[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal_x   <= nv[0];
      normal_y   <= nv[1];
      normal_z   <= nv[2];
      degenerate <= dv_c[Q_W].dg;
    end
  end

  // a degenerate result carries a zero vector
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("degenerate result with nonzero normal");

  // components stay within unit range
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x >= -16384 && normal_x <= 16384
               && normal_y >= -16384 && normal_y <= 16384
               && normal_z >= -16384 && normal_z <= 16384)
    else $error("normal component out of unit range");

  // a held result freezes the whole pipe
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vld))
    else $error("pipeline moved while output stalled");

endmodule
